@@ hdl/grnn_ik_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grnn_ik_pkg
// Shared constants, types and elaboration-time helpers for the regression
// network inverse kinematics block.
// ----------------------------------------------------------------------------
package grnn_ik_pkg;

    // Default sizes
    localparam int DEF_ENTRY_COUNT     = 1024;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int SPREAD_W = 16;
    localparam int EUSED_W  = 11;
    localparam int WEIGHT_W = 17;
    localparam int ENTRY_W  = 6 * COORD_W;
    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 96;
    localparam int PADDR_W  = 3;

    // Arithmetic constants
    localparam logic [15:0] KERNEL_K      = 16'd45431;   // 0.8326^2, Q0.16
    localparam logic [21:0] RAD_TO_DEG    = 22'd3754936; // 180/pi, Q16.16
    localparam int          U_BITS        = 20;          // u below 16.0 in Q16.16
    localparam int          DIST_BITS     = 40;          // distances at 2^40 are far
    localparam int          ANG_Q_W       = 33;          // average quotient bits

    // Register reset values
    localparam logic [SPREAD_W-1:0] SPREAD_RST = 16'd512;
    localparam logic [EUSED_W-1:0]  EUSED_RST  = 11'd1024;

    // Register indexes (paddr bit 2)
    localparam logic REG_SPREAD = 1'b0;
    localparam logic REG_EUSED  = 1'b1;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_DIFF,
        ST_SQ,
        ST_DIST,
        ST_KMUL,
        ST_KCHK,
        ST_KDIV,
        ST_WGT,
        ST_PROD,
        ST_ACC,
        ST_FIN,
        ST_DSTART,
        ST_DWAIT,
        ST_DEG,
        ST_SAT
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic rd_en;
        logic kdiv_start;
        logic adiv_start;
    } ctrl_t;

    // Integer square root, elaboration only
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = v;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // exp(-u) in Q1.16 for u in Q16.16, built from 2^(-2^-i) factors
    function automatic logic [WEIGHT_W-1:0] exp_neg_q16(logic [63:0] u);
        logic [63:0] fac [17];
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] p;
        fac[0] = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) fac[i] = isqrt64(fac[i-1] << 30);
        y = (u * 64'd94548) >> 16;
        n = y >> 16;
        f = y & 64'hFFFF;
        p = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
            if (f[16-i]) p = (p * fac[i]) >> 30;
        if (n >= 40) return '0;
        p = p >> n;
        return WEIGHT_W'((p + 64'd8192) >> 14);
    endfunction

endpackage

@@ hdl/grnn_ik_entry_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grnn_ik_entry_mem
// Network entry store: centre and three targets per word, one write port,
// one read port with registered data.
// ----------------------------------------------------------------------------
module grnn_ik_entry_mem #(
    parameter int ENTRY_COUNT = 1024,
    parameter int ADDR_W      = 10,
    parameter int DATA_W      = 192
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_q [ENTRY_COUNT];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    // Read port, registered data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_q[rd_addr];
        end
    end

endmodule

@@ hdl/grnn_ik_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grnn_ik_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2^Q_W, so only Q_W quotient bits are produced.
// ----------------------------------------------------------------------------
module grnn_ik_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24,
    parameter int Q_W   = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // One trial subtraction
    always_comb
    begin
        trial = {rem_reg, low_reg[Q_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_W'(num >> Q_W);
            low_reg  <= num[Q_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[Q_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hdl/grnn_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grnn_inverse_kinematics
// Regression network evaluator mapping a 3-D target to three joint angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser = cmd (0 load, 1 query). A load writes one
//   entry (centre and three radian targets) in its accept cycle and gives no
//   result. A query walks entries 0 .. entries_used-1, clipped to the store
//   depth, and gives one result on m_axis_* with the three angles in degrees
//   and no_match in tuser. APB port: spread at 0x0, entries_used at 0x4; write only while idle.
// Sequence:
//   A load completes in its accept cycle. A query takes each walked near
//   entry through the memory read, squares, kernel scaling, the kernel
//   divide, the weight lookup and the multiply-accumulate, while a far entry
//   skips the divide; then each angle goes through the final 33-bit divide
//   and degree scaling. One request at a time.
// Reset:
//   Registers return to spread = 2.0, entries_used = 1024; the entry store is
//   not cleared, entries must be loaded before a query walks them.
// Stall:
//   A result waits in the output register; the next request is accepted
//   meanwhile, and a finished query holds until the register is free.
// ----------------------------------------------------------------------------
module grnn_inverse_kinematics #(
    parameter int ENTRY_COUNT     = grnn_ik_pkg::DEF_ENTRY_COUNT,
    parameter int EXP_TABLE_DEPTH = grnn_ik_pkg::DEF_EXP_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: entry_index, pos_x, pos_y, pos_z, target_first, target_second,
    //        target_third (lowest bit up), zero padded
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [grnn_ik_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                             s_axis_tuser,   // cmd
    // tdata: angle_first, angle_second, angle_third (lowest bit up)
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [grnn_ik_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser,   // no_match
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [grnn_ik_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import grnn_ik_pkg::*;

    localparam int AW      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW      = $clog2(ENTRY_COUNT + 1);
    localparam int ROM_AW  = $clog2(EXP_TABLE_DEPTH);
    localparam int W_W     = WEIGHT_W + AW;
    localparam int PROD_W  = WEIGHT_W + COORD_W;
    localparam int ACC_W   = PROD_W + AW;
    localparam int ANUM_W  = ACC_W + 1;
    localparam int KNUM_W  = DIST_BITS + 16;
    localparam int KDEN_W  = SPREAD_W + 8;
    localparam int IDX_W   = U_BITS + ROM_AW + 1;
    localparam int DEG_W   = ANUM_W > 0 ? ANG_Q_W + 22 : 0;

    // ---- weight table ----
    logic [WEIGHT_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] U_G = (64'(g) << U_BITS) / EXP_TABLE_DEPTH;
        assign exp_rom[g] = exp_neg_q16(U_G);
    end

    // ---- registers ----
    state_t                state_reg, state_next;
    ctrl_t                 ctrl;
    logic [SPREAD_W-1:0]   spread_reg;
    logic [EUSED_W-1:0]    eused_reg;
    logic [CW-1:0]         ent_reg;
    logic [CW-1:0]         walk_reg;
    logic [1:0]            sel_reg;
    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic                  m_user_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COORD_W-1:0]        dx_reg, dy_reg, dz_reg;
    logic signed [COORD_W-1:0] tgt_reg [3];
    logic [47:0]               sx_reg, sy_reg, sz_reg;
    logic [49:0]               dist_reg;
    logic [KNUM_W-1:0]         kn_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic [W_W-1:0]            wsum_reg;
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic                      neg_reg;
    logic [DEG_W-1:0]          deg_reg;
    logic [COORD_W-1:0]        res_reg [3];
    logic                      nomatch_reg;

    // ---- combinational helpers ----
    logic                  s_acc;
    logic                  q_acc;
    logic                  out_free;
    logic [CW-1:0]         walk_calc;
    logic [SPREAD_W-1:0]   sp_eff;
    logic [KDEN_W-1:0]     kden;
    logic                  kzero;
    logic                  kdone;
    logic [U_BITS-1:0]     u_q;
    logic [IDX_W-1:0]      idx_full;
    logic [WEIGHT_W-1:0]   w_lookup;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  adone;
    logic [ANG_Q_W-1:0]    a_q;
    logic [ACC_W-1:0]      a_mag;
    logic [ANUM_W-1:0]     a_num;
    logic [DEG_W-16:0]     dg;
    logic [COORD_W-1:0]    sat_val;
    logic                  last_ent;

    // |a - b| of two signed coordinates, fits 32 bits
    function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                    logic [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    endfunction

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign q_acc    = s_acc && (s_axis_tuser == CMD_QUERY);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign last_ent = (ent_reg == walk_reg - 1'b1);

    // Walk length clipped to the store depth
    always_comb
    begin
        walk_calc = (32'(eused_reg) > ENTRY_COUNT) ? CW'(ENTRY_COUNT) : CW'(eused_reg);
    end

    // Kernel scaling: zero weight when far or u >= 16.0
    always_comb
    begin
        sp_eff = (spread_reg == '0) ? SPREAD_W'(1) : spread_reg;
        kden   = {sp_eff, 8'd0};
        kzero  = (dist_reg >= (50'd1 << DIST_BITS)) ||
                 (kn_reg >= (KNUM_W'(kden) << U_BITS));
    end

    // Table index, round(u * depth / 16)
    always_comb
    begin
        idx_full = (IDX_W'(u_q) * IDX_W'(EXP_TABLE_DEPTH) + (IDX_W'(1) << (U_BITS - 1)))
                   >> U_BITS;
        if (idx_full >= IDX_W'(EXP_TABLE_DEPTH))
            w_lookup = '0;
        else
            w_lookup = exp_rom[idx_full[ROM_AW-1:0]];
    end

    // Final divide operand: |acc| + wsum/2
    always_comb
    begin
        a_mag = acc_reg[sel_reg][ACC_W-1] ? ACC_W'(-acc_reg[sel_reg])
                                          : ACC_W'(acc_reg[sel_reg]);
        a_num = ANUM_W'(a_mag) + ANUM_W'(wsum_reg >> 1);
    end

    // Degree rounding and saturation
    always_comb
    begin
        dg = (DEG_W-15)'((deg_reg + DEG_W'(32768)) >> 16);
        if (neg_reg)
        begin
            if (dg > (DEG_W-15)'(32'h8000_0000))
                sat_val = 32'h8000_0000;
            else
                sat_val = COORD_W'(-dg);
        end
        else
        begin
            if (dg > (DEG_W-15)'(32'h7FFF_FFFF))
                sat_val = 32'h7FFF_FFFF;
            else
                sat_val = COORD_W'(dg);
        end
    end

    // ---- entry store ----
    grnn_ik_entry_mem #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .ADDR_W      (AW),
        .DATA_W      (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (s_acc && (s_axis_tuser == CMD_LOAD) &&
                  (32'(s_axis_tdata[INDEX_W-1:0]) < ENTRY_COUNT)),
        .wr_addr (AW'(s_axis_tdata[INDEX_W-1:0])),
        .wr_data (s_axis_tdata[INDEX_W+ENTRY_W-1:INDEX_W]),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ent_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // ---- kernel divider: u = K*d / (256*spread) ----
    grnn_ik_div #(
        .NUM_W (KNUM_W),
        .DEN_W (KDEN_W),
        .Q_W   (U_BITS)
    ) u_kdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.kdiv_start),
        .num   (kn_reg),
        .den   (kden),
        .done  (kdone),
        .quot  (u_q)
    );

    // ---- average divider: round(|acc| / wsum) ----
    grnn_ik_div #(
        .NUM_W (ANUM_W),
        .DEN_W (W_W),
        .Q_W   (ANG_Q_W)
    ) u_adiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.adiv_start),
        .num   (a_num),
        .den   (wsum_reg),
        .done  (adone),
        .quot  (a_q)
    );

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_acc) state_next = (walk_calc == '0) ? ST_FIN : ST_RD;
            ST_RD:     state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_SQ;
            ST_SQ:     state_next = ST_DIST;
            ST_DIST:   state_next = ST_KMUL;
            ST_KMUL:   state_next = ST_KCHK;
            ST_KCHK:   state_next = kzero ? ST_PROD : ST_KDIV;
            ST_KDIV:   if (kdone) state_next = ST_WGT;
            ST_WGT:    state_next = ST_PROD;
            ST_PROD:   state_next = ST_ACC;
            ST_ACC:    state_next = last_ent ? ST_FIN : ST_RD;
            ST_FIN:
            begin
                if (wsum_reg == '0)
                begin
                    if (out_free) state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (adone) state_next = ST_DEG;
            ST_DEG:    state_next = ST_SAT;
            ST_SAT:
            begin
                if (sel_reg != 2'd2)
                    state_next = ST_DSTART;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        ctrl            = '0;
        ctrl.s_ready    = (state_reg == ST_IDLE);
        ctrl.rd_en      = (state_reg == ST_RD);
        ctrl.kdiv_start = (state_reg == ST_KCHK) && !kzero;
        ctrl.adiv_start = (state_reg == ST_DSTART);
    end

    assign s_axis_tready = ctrl.s_ready;

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            spread_reg  <= SPREAD_RST;
            eused_reg   <= EUSED_RST;
            m_valid_reg <= 1'b0;
            ent_reg     <= '0;
            walk_reg    <= '0;
            sel_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // configuration writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SPREAD)
                    spread_reg <= pwdata[SPREAD_W-1:0];
                else
                    eused_reg <= pwdata[EUSED_W-1:0];
            end
            // entry walk
            if (q_acc)
            begin
                ent_reg  <= '0;
                walk_reg <= walk_calc;
            end
            else if (state_reg == ST_ACC)
            begin
                ent_reg <= ent_reg + 1'b1;
            end
            // angle select
            if (state_reg == ST_FIN)
                sel_reg <= '0;
            else if (state_reg == ST_SAT && sel_reg != 2'd2)
                sel_reg <= sel_reg + 1'b1;
            // result register
            if (((state_reg == ST_FIN && wsum_reg == '0) ||
                 (state_reg == ST_SAT && sel_reg == 2'd2)) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_acc)
                begin
                    px_reg   <= s_axis_tdata[INDEX_W+COORD_W-1:INDEX_W];
                    py_reg   <= s_axis_tdata[INDEX_W+2*COORD_W-1:INDEX_W+COORD_W];
                    pz_reg   <= s_axis_tdata[INDEX_W+3*COORD_W-1:INDEX_W+2*COORD_W];
                    wsum_reg <= '0;
                    for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
                end
            end
            ST_DIFF:
            begin
                // centre differences, magnitudes fit 32 bits
                dx_reg <= abs_diff(px_reg, rd_data[31:0]);
                dy_reg <= abs_diff(py_reg, rd_data[63:32]);
                dz_reg <= abs_diff(pz_reg, rd_data[95:64]);
                tgt_reg[0] <= rd_data[127:96];
                tgt_reg[1] <= rd_data[159:128];
                tgt_reg[2] <= rd_data[191:160];
            end
            ST_SQ:
            begin
                sx_reg <= 48'((64'(dx_reg) * 64'(dx_reg)) >> 16);
                sy_reg <= 48'((64'(dy_reg) * 64'(dy_reg)) >> 16);
                sz_reg <= 48'((64'(dz_reg) * 64'(dz_reg)) >> 16);
            end
            ST_DIST:
                dist_reg <= 50'(sx_reg) + 50'(sy_reg) + 50'(sz_reg);
            ST_KMUL:
                kn_reg <= KNUM_W'(dist_reg[DIST_BITS-1:0]) * KNUM_W'(KERNEL_K);
            ST_KCHK:
                if (kzero) w_reg <= '0;
            ST_WGT:
                w_reg <= w_lookup;
            ST_PROD:
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[k] <= $signed({1'b0, w_reg}) * tgt_reg[k];
            end
            ST_ACC:
            begin
                wsum_reg <= wsum_reg + W_W'(w_reg);
                for (int k = 0; k < 3; k++)
                    acc_reg[k] <= acc_reg[k] + ACC_W'(prod_reg[k]);
            end
            ST_FIN:
            begin
                nomatch_reg <= (wsum_reg == '0);
                for (int k = 0; k < 3; k++) res_reg[k] <= '0;
            end
            ST_DSTART:
                neg_reg <= acc_reg[sel_reg][ACC_W-1];
            ST_DEG:
                deg_reg <= DEG_W'(a_q) * DEG_W'(RAD_TO_DEG);
            ST_SAT:
                res_reg[sel_reg] <= sat_val;
            default:
            begin
            end
        endcase
    end

    // Output payload load
    always_ff @(posedge clk)
    begin
        if (out_free && state_reg == ST_FIN && wsum_reg == '0)
        begin
            m_data_reg <= '0;
            m_user_reg <= 1'b1;
        end
        else if (out_free && state_reg == ST_SAT && sel_reg == 2'd2)
        begin
            m_data_reg <= {sat_val, res_reg[1], res_reg[0]};
            m_user_reg <= nomatch_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // APB read and ready
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EUSED) ? 32'(eused_reg) : 32'(spread_reg);

endmodule

@@ hdl/grnn_ik_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grnn_ik_checker
// Port-level checks for the regression network block, bound to the top.
// ----------------------------------------------------------------------------
module grnn_ik_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        pready
);

    import grnn_ik_pkg::*;

    // Config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // Result stays valid while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // no_match comes with zero angles
    a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("no_match with nonzero angles");

    // A load never makes a result
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after load");

    // A query result is never ready in the next cycle
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_QUERY && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("query result too early");

endmodule

bind grnn_inverse_kinematics grnn_ik_checker u_grnn_ik_checker (.*);
